>>> hdl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants for the MQTT PUBLISH deframer
// Holds the field widths, the packet type code and the result beat structure
// that passes between the parser and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  // Field and counter widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 28;
  localparam int unsigned TopicW  = 16;
  localparam int unsigned KindW   = 4;
  localparam int unsigned LenCntW = 3;

  // Longest remaining-length field, in bytes.
  localparam logic [LenCntW-1:0] MaxLengthBytes = 3'd4;

  // Packet type code of a PUBLISH packet.
  localparam logic [KindW-1:0] KindPublish = 4'd3;

  // One result beat as produced by the parser.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] msg_byte;
    logic             msg_last;
    logic             frame_error;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/mqtt_publish_deframer.sv
// ----------------------------------------------------------------------------
// mqtt_publish_deframer: MQTT PUBLISH message extractor
// The rx channel carries the broker byte stream, one byte per beat. The msg
// channel returns the message bytes of PUBLISH packets, with msg_last_o on the
// final byte of each message, or a single beat with frame_error_o set when a
// remaining-length field runs past four bytes; the block then ignores all
// further bytes until reset. Other packet types, empty messages and bodies
// too short for their topic produce no beats.
// A byte accepted on the rx channel lands in the input register, is parsed
// there by the parser and any result is held in the result register, which
// drives the msg channel. One byte is taken every cycle while no result
// waits under msg_stall_i, as the per-byte update is one short parser step.
// While a result waits under msg_stall_i, one more byte is held in the input
// register and rx_stall_o rises until the result is taken.
// Reset clears the parser to expect a fixed header byte and empties both
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_publish_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            msg_valid_o,
  input  wire logic       msg_stall_i,
  output logic [7:0]      msg_byte_o,
  output logic            msg_last_o,
  output logic            frame_error_o
);

  logic                      in_valid_q;
  logic [mpd_pkg::ByteW-1:0] in_byte_q;
  logic                      out_valid_q;
  logic [mpd_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q;
  logic                      out_err_q;
  logic                      out_ready;
  logic                      step;
  logic                      rx_accept;
  mpd_pkg::result_t          res;

  // The output register can take a new beat when empty or being drained.
  assign out_ready  = !out_valid_q || !msg_stall_i;
  assign step       = in_valid_q && out_ready;
  assign rx_stall_o = in_valid_q && !out_ready;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  mpd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || step) begin
      in_valid_q <= rx_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && out_ready) begin
      out_byte_q <= res.msg_byte;
      out_last_q <= res.msg_last;
      out_err_q  <= res.frame_error;
    end
  end

  assign msg_valid_o   = out_valid_q;
  assign msg_byte_o    = out_byte_q;
  assign msg_last_o    = out_last_q;
  assign frame_error_o = out_err_q;

endmodule

`default_nettype wire

>>> hdl/mpd_parser.sv
// ----------------------------------------------------------------------------
// mpd_parser: per-byte packet state machine
// Holds the framing state and, for the byte offered on byte_i, works out the
// result beat and the next state. The state advances when step_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [mpd_pkg::ByteW-1:0] byte_i,
  output mpd_pkg::result_t               res_o
);

  typedef enum logic [2:0] {
    PhHeader,
    PhLength,
    PhTopicHi,
    PhTopicLo,
    PhTopic,
    PhMessage,
    PhSkip,
    PhHalt
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [mpd_pkg::KindW-1:0]       kind_q, kind_d;
  logic [mpd_pkg::LenW-1:0]        len_sum_q, len_sum_d;
  logic [mpd_pkg::LenCntW-1:0]     len_cnt_q, len_cnt_d;
  logic [mpd_pkg::LenW-1:0]        left_q, left_d;
  logic [mpd_pkg::ByteW-1:0]       topic_hi_q, topic_hi_d;
  logic [mpd_pkg::TopicW-1:0]      topic_left_q, topic_left_d;

  logic [mpd_pkg::LenW-1:0]        len_term;
  logic [mpd_pkg::LenW-1:0]        len_new;
  logic [mpd_pkg::LenCntW-1:0]     cnt_new;
  logic [mpd_pkg::LenW-1:0]        left_dec;
  logic [mpd_pkg::TopicW-1:0]      topic_new;
  logic [mpd_pkg::TopicW-1:0]      topic_dec;

  // Place the 7-bit length group at the weight of its position.
  always_comb begin
    case (len_cnt_q[1:0])
      2'd0:    len_term = {21'd0, byte_i[6:0]};
      2'd1:    len_term = {14'd0, byte_i[6:0], 7'd0};
      2'd2:    len_term = {7'd0, byte_i[6:0], 14'd0};
      default: len_term = {byte_i[6:0], 21'd0};
    endcase
  end

  assign len_new   = len_sum_q + len_term;
  assign cnt_new   = len_cnt_q + 3'd1;
  assign left_dec  = left_q - 28'd1;
  assign topic_new = {topic_hi_q, byte_i};
  assign topic_dec = topic_left_q - 16'd1;

  // Next state and result for the current byte.
  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    len_sum_d    = len_sum_q;
    len_cnt_d    = len_cnt_q;
    left_d       = left_q;
    topic_hi_d   = topic_hi_q;
    topic_left_d = topic_left_q;
    res_o        = '0;
    case (phase_q)
      PhHeader: begin
        kind_d    = byte_i[7:4];
        len_sum_d = '0;
        len_cnt_d = '0;
        phase_d   = PhLength;
      end
      PhLength: begin
        len_sum_d = len_new;
        len_cnt_d = cnt_new;
        if (byte_i[7]) begin
          if (cnt_new >= mpd_pkg::MaxLengthBytes) begin
            phase_d           = PhHalt;
            res_o.valid       = 1'b1;
            res_o.frame_error = 1'b1;
          end
        end else begin
          left_d = len_new;
          if (len_new == '0) begin
            phase_d = PhHeader;
          end else if (kind_q == mpd_pkg::KindPublish) begin
            phase_d = PhTopicHi;
          end else begin
            phase_d = PhSkip;
          end
        end
      end
      PhTopicHi: begin
        topic_hi_d = byte_i;
        left_d     = left_dec;
        phase_d    = (left_dec == '0) ? PhHeader : PhTopicLo;
      end
      PhTopicLo: begin
        topic_left_d = topic_new;
        left_d       = left_dec;
        if ({12'd0, topic_new} >= left_dec) begin
          // The topic fills or overruns the body: nothing to emit.
          phase_d = (left_dec == '0) ? PhHeader : PhSkip;
        end else begin
          phase_d = (topic_new == '0) ? PhMessage : PhTopic;
        end
      end
      PhTopic: begin
        topic_left_d = topic_dec;
        left_d       = left_dec;
        if (topic_dec == '0) begin
          phase_d = (left_dec == '0) ? PhHeader : PhMessage;
        end
      end
      PhMessage: begin
        left_d         = left_dec;
        phase_d        = (left_dec == '0) ? PhHeader : PhMessage;
        res_o.valid    = 1'b1;
        res_o.msg_byte = byte_i;
        res_o.msg_last = (left_dec == '0);
      end
      PhSkip: begin
        left_d  = left_dec;
        phase_d = (left_dec == '0) ? PhHeader : PhSkip;
      end
      default: begin
        phase_d = PhHalt;
      end
    endcase
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      kind_q       <= '0;
      len_sum_q    <= '0;
      len_cnt_q    <= '0;
      left_q       <= '0;
      topic_hi_q   <= '0;
      topic_left_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      len_sum_q    <= len_sum_d;
      len_cnt_q    <= len_cnt_d;
      left_q       <= left_d;
      topic_hi_q   <= topic_hi_d;
      topic_left_q <= topic_left_d;
    end
  end

endmodule

`default_nettype wire
